>>> hw/rtl/iaod_pkg.sv
// shared constants, codes and helpers for the imu axis orientation detector
// used by iaod_mul and imu_axis_orientation_detect
`default_nettype none
package iaod_pkg;

  localparam int MAX_SAMPLES = 1024;
  localparam int CNT_W       = $clog2(MAX_SAMPLES + 1);
  localparam int SUM_W       = 16 + $clog2(MAX_SAMPLES) + 1;
  localparam int SQ_W        = 32 + $clog2(MAX_SAMPLES);
  localparam int SHORT_LIMIT = 20;
  localparam int CFG_W       = 15;

  localparam int MUL_A_W = 32;
  localparam int MUL_B_W = 16;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;
  localparam int D_W     = SUM_W + CNT_W + 1;

  localparam logic [1:0] ACT_CLEAR  = 2'd0;
  localparam logic [1:0] ACT_SAMPLE = 2'd1;
  localparam logic [1:0] ACT_EVAL   = 2'd2;
  localparam logic [1:0] ACT_NONE   = 2'd3;

  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_NO_GRAV = 2'd1;
  localparam logic [1:0] STAT_NO_ROLL = 2'd2;

  localparam logic [2:0] REG_GRAVITY_MIN = 3'd0;
  localparam logic [2:0] REG_ROLL_MIN    = 3'd1;
  localparam logic [2:0] REG_PITCH_WARN  = 3'd2;
  localparam logic [2:0] REG_YAW_RMS     = 3'd3;
  localparam logic [2:0] REG_TAP_THR     = 3'd4;

  function automatic logic [SUM_W-1:0] abs_sum(input logic signed [SUM_W-1:0] v);
    return v[SUM_W-1] ? SUM_W'(-v) : v;
  endfunction

  function automatic logic [D_W-1:0] abs_d(input logic signed [D_W-1:0] v);
    return v[D_W-1] ? D_W'(-v) : v;
  endfunction

endpackage
`default_nettype wire

>>> hw/rtl/iaod_mul.sv
// shared signed multiplier with a registered product
// depends on iaod_pkg for operand widths
`default_nettype none
module iaod_mul (
  input  wire logic                                clk,
  input  wire logic signed [iaod_pkg::MUL_A_W-1:0] mul_a,
  input  wire logic signed [iaod_pkg::MUL_B_W-1:0] mul_b,
  output logic signed [iaod_pkg::MUL_P_W-1:0]      prod_r
);

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
  end

endmodule
`default_nettype wire

>>> hw/rtl/imu_axis_orientation_detect.sv
// imu axis orientation detector: phase sums, tap check and axis mapping
// requests are handled one at a time
// a new request is taken only while idle and once the previous result has been handed off
// all steps share one 32x16 multiplier (iaod_mul)
// reset (rst_n low, synchronous) clears all sums and counts and loads default thresholds
`default_nettype none
module imu_axis_orientation_detect (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z
  input  wire logic [95:0] in_tdata,
  // action, phase
  input  wire logic [3:0]  in_tuser,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // tap_detected, status, warnings, roll_sel, pitch_sel, gravity_axis,
  // yaw_sel, invert_flags, short_phases, zero fill
  output logic [23:0]      out_tdata,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [14:0] cfg_data
);

  localparam int SW = iaod_pkg::SUM_W;
  localparam int CW = iaod_pkg::CNT_W;
  localparam int DW = iaod_pkg::D_W;
  localparam int QW = iaod_pkg::SQ_W;
  localparam int AW = iaod_pkg::MUL_A_W;
  localparam int BW = iaod_pkg::MUL_B_W;
  localparam int PW = iaod_pkg::MUL_P_W;

  typedef enum logic [1:0] {ST_IDLE, ST_ACC, ST_EVAL} state_t;

  state_t state_r;
  logic [4:0] step_r;

  logic [14:0] gmin_r, rmin_r, pmin_r, ymin_r, tthr_r;

  logic signed [SW-1:0] acc_sum_r [9];
  logic signed [SW-1:0] gyr_sum_r [9];
  logic [QW-1:0]        sq_r [3];
  logic [CW-1:0]        cnt_r [4];

  logic [1:0] phase_r;
  logic signed [15:0] ax_r, ay_r, az_r, gx_r, gy_r, gz_r;
  logic ok_r;
  logic [32:0] m2_r;

  logic signed [PW-1:0] t_r;
  logic signed [DW-1:0] d_r [3];
  logic [DW-1:0] dpm_r;
  logic [1:0] g_r, r_r, y_r;
  logic [5:0] inv_r;
  logic [1:0] warn_r;

  logic out_valid_r, o_tap_r;
  logic [1:0] o_stat_r, o_warn_r, o_roll_r, o_pitch_r, o_grav_r, o_yaw_r;
  logic [5:0] o_inv_r;
  logic [3:0] o_short_r;

  logic signed [AW-1:0] mul_a;
  logic signed [BW-1:0] mul_b;
  logic signed [PW-1:0] prod_r;

  iaod_mul u_mul (.clk(clk), .mul_a(mul_a), .mul_b(mul_b), .prod_r(prod_r));

  assign in_tready = (state_r == ST_IDLE) && !out_valid_r;
  assign cfg_ready = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata = {1'b0, o_short_r, o_inv_r, o_yaw_r, o_grav_r, o_pitch_r, o_roll_r,
                      o_warn_r, o_stat_r, o_tap_r};

  logic [CW-1:0] nf, nr, nt, ns;
  assign nf = (cnt_r[0] == '0) ? CW'(1) : cnt_r[0];
  assign nr = (cnt_r[1] == '0) ? CW'(1) : cnt_r[1];
  assign nt = (cnt_r[2] == '0) ? CW'(1) : cnt_r[2];
  assign ns = (cnt_r[3] == '0) ? CW'(1) : cnt_r[3];

  logic [3:0] short_ph;
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      short_ph[k] = cnt_r[k] < CW'(iaod_pkg::SHORT_LIMIT);
    end
  end

  // gravity axis: largest flat magnitude, lowest index on ties
  logic [1:0] g_sel;
  always_comb begin
    g_sel = 2'd0;
    if (iaod_pkg::abs_sum(acc_sum_r[1]) > iaod_pkg::abs_sum(acc_sum_r[0])) begin
      g_sel = 2'd1;
    end
    if (iaod_pkg::abs_sum(acc_sum_r[2]) > iaod_pkg::abs_sum(acc_sum_r[4'(g_sel)])) begin
      g_sel = 2'd2;
    end
  end

  // roll axis among the two non-gravity axes
  logic [1:0] r_sel;
  always_comb begin
    r_sel = (g_r == 2'd0) ? 2'd1 : 2'd0;
    for (int k = 0; k < 3; k++) begin
      if (2'(k) != g_r && iaod_pkg::abs_d(d_r[k]) > iaod_pkg::abs_d(d_r[r_sel])) begin
        r_sel = 2'(k);
      end
    end
  end

  logic [1:0] p_ax;
  assign p_ax = 2'(3 - {2'b0, g_r} - {2'b0, r_r});

  function automatic logic [1:0] mod3(input logic [2:0] v);
    return (v >= 3'd3) ? 2'(v - 3'd3) : v[1:0];
  endfunction

  function automatic logic sq_beats(input logic [QW-1:0] a, input logic [QW-1:0] b);
    return {2'b0, a, 2'b0} > ({1'b0, b, 3'b0} + {4'b0, b});
  endfunction

  logic [1:0] y_up1, y_up2;
  assign y_up1 = mod3({1'b0, g_r} + 3'd1);
  assign y_up2 = mod3({1'b0, g_r} + 3'd2);

  function automatic logic signed [AW-1:0] sx_sum(input logic signed [SW-1:0] v);
    return AW'(v);
  endfunction

  function automatic logic signed [BW-1:0] ub(input logic [CW-1:0] v);
    return BW'(v);
  endfunction

  // operand selection for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state_r == ST_ACC) begin
      case (step_r)
        5'd0: begin mul_a = AW'(ax_r); mul_b = ax_r; end
        5'd1: begin mul_a = AW'(ay_r); mul_b = ay_r; end
        5'd2: begin mul_a = AW'(az_r); mul_b = az_r; end
        5'd3: begin mul_a = AW'(tthr_r); mul_b = BW'(tthr_r); end
        5'd4: begin mul_a = AW'(gx_r); mul_b = gx_r; end
        5'd5: begin mul_a = AW'(gy_r); mul_b = gy_r; end
        5'd6: begin mul_a = AW'(gz_r); mul_b = gz_r; end
        default: ;
      endcase
    end else if (state_r == ST_EVAL) begin
      case (step_r)
        5'd0:  begin mul_a = AW'(gmin_r); mul_b = ub(nf); end
        5'd1:  begin mul_a = sx_sum(acc_sum_r[3]); mul_b = ub(nf); end
        5'd2:  begin mul_a = sx_sum(acc_sum_r[0]); mul_b = ub(nr); end
        5'd3:  begin mul_a = sx_sum(acc_sum_r[4]); mul_b = ub(nf); end
        5'd4:  begin mul_a = sx_sum(acc_sum_r[1]); mul_b = ub(nr); end
        5'd5:  begin mul_a = sx_sum(acc_sum_r[5]); mul_b = ub(nf); end
        5'd6:  begin mul_a = sx_sum(acc_sum_r[2]); mul_b = ub(nr); end
        5'd7:  begin mul_a = AW'(rmin_r); mul_b = ub(nr); end
        5'd8:  begin mul_a = prod_r[AW-1:0]; mul_b = ub(nf); end
        5'd9:  begin mul_a = sx_sum(acc_sum_r[4'd6 + 4'(p_ax)]); mul_b = ub(nf); end
        5'd10: begin mul_a = sx_sum(acc_sum_r[4'(p_ax)]); mul_b = ub(nt); end
        5'd11: begin mul_a = AW'(pmin_r); mul_b = ub(nt); end
        5'd12: begin mul_a = prod_r[AW-1:0]; mul_b = ub(nf); end
        5'd13: begin mul_a = AW'(ymin_r); mul_b = BW'(ymin_r); end
        5'd14: begin mul_a = prod_r[AW-1:0]; mul_b = ub(ns); end
        default: ;
      endcase
    end
  end

  logic [PW-1:0] prod_u;
  assign prod_u = prod_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
      gmin_r      <= 15'd2458;
      rmin_r      <= 15'd819;
      pmin_r      <= 15'd614;
      ymin_r      <= 15'd80;
      tthr_r      <= 15'd7373;
      for (int k = 0; k < 9; k++) begin
        acc_sum_r[k] <= '0;
        gyr_sum_r[k] <= '0;
      end
      for (int k = 0; k < 3; k++) sq_r[k] <= '0;
      for (int k = 0; k < 4; k++) cnt_r[k] <= '0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          iaod_pkg::REG_GRAVITY_MIN: gmin_r <= cfg_data;
          iaod_pkg::REG_ROLL_MIN:    rmin_r <= cfg_data;
          iaod_pkg::REG_PITCH_WARN:  pmin_r <= cfg_data;
          iaod_pkg::REG_YAW_RMS:     ymin_r <= cfg_data;
          iaod_pkg::REG_TAP_THR:     tthr_r <= cfg_data;
          default: ;
        endcase
      end
      if (out_valid_r && out_tready) out_valid_r <= 1'b0;

      case (state_r)
        ST_IDLE: begin
          if (in_tvalid && in_tready) begin
            phase_r <= in_tuser[3:2];
            ax_r <= in_tdata[15:0];
            ay_r <= in_tdata[31:16];
            az_r <= in_tdata[47:32];
            gx_r <= in_tdata[63:48];
            gy_r <= in_tdata[79:64];
            gz_r <= in_tdata[95:80];
            step_r <= '0;
            o_tap_r <= 1'b0; o_stat_r <= iaod_pkg::STAT_OK; o_warn_r <= '0;
            o_roll_r <= '0; o_pitch_r <= '0; o_grav_r <= '0; o_yaw_r <= '0;
            o_inv_r <= '0; o_short_r <= '0;
            case (in_tuser[1:0])
              iaod_pkg::ACT_SAMPLE: state_r <= ST_ACC;
              iaod_pkg::ACT_EVAL:   state_r <= ST_EVAL;
              iaod_pkg::ACT_CLEAR: begin
                for (int k = 0; k < 9; k++) begin
                  acc_sum_r[k] <= '0;
                  gyr_sum_r[k] <= '0;
                end
                for (int k = 0; k < 3; k++) sq_r[k] <= '0;
                for (int k = 0; k < 4; k++) cnt_r[k] <= '0;
                out_valid_r <= 1'b1;
              end
              default: out_valid_r <= 1'b1;
            endcase
          end
        end

        ST_ACC: begin
          step_r <= step_r + 5'd1;
          case (step_r)
            5'd0: begin
              ok_r <= cnt_r[phase_r] < CW'(iaod_pkg::MAX_SAMPLES);
              if (cnt_r[phase_r] < CW'(iaod_pkg::MAX_SAMPLES)) begin
                cnt_r[phase_r] <= cnt_r[phase_r] + CW'(1);
                for (int ph = 0; ph < 3; ph++) begin
                  if (phase_r == 2'(ph)) begin
                    acc_sum_r[ph*3]   <= acc_sum_r[ph*3]   + SW'(ax_r);
                    acc_sum_r[ph*3+1] <= acc_sum_r[ph*3+1] + SW'(ay_r);
                    acc_sum_r[ph*3+2] <= acc_sum_r[ph*3+2] + SW'(az_r);
                  end
                  if (phase_r == 2'(ph + 1)) begin
                    gyr_sum_r[ph*3]   <= gyr_sum_r[ph*3]   + SW'(gx_r);
                    gyr_sum_r[ph*3+1] <= gyr_sum_r[ph*3+1] + SW'(gy_r);
                    gyr_sum_r[ph*3+2] <= gyr_sum_r[ph*3+2] + SW'(gz_r);
                  end
                end
              end
            end
            5'd1: m2_r <= prod_u[32:0];
            5'd2: m2_r <= m2_r + prod_u[32:0];
            5'd3: m2_r <= m2_r + prod_u[32:0];
            5'd4: o_tap_r <= m2_r > prod_u[32:0];
            5'd5: if (ok_r && phase_r == 2'd3) sq_r[0] <= sq_r[0] + QW'(prod_u[31:0]);
            5'd6: if (ok_r && phase_r == 2'd3) sq_r[1] <= sq_r[1] + QW'(prod_u[31:0]);
            default: begin
              if (ok_r && phase_r == 2'd3) sq_r[2] <= sq_r[2] + QW'(prod_u[31:0]);
              out_valid_r <= 1'b1;
              state_r <= ST_IDLE;
            end
          endcase
        end

        ST_EVAL: begin
          step_r <= step_r + 5'd1;
          case (step_r)
            5'd0: begin
              g_r <= g_sel;
              inv_r <= '0;
              warn_r <= '0;
            end
            5'd1: begin
              if ({{(PW-SW){1'b0}}, iaod_pkg::abs_sum(acc_sum_r[4'(g_r)])} < prod_u) begin
                o_stat_r <= iaod_pkg::STAT_NO_GRAV;
                o_short_r <= short_ph;
                out_valid_r <= 1'b1;
                state_r <= ST_IDLE;
              end
              inv_r[2] <= acc_sum_r[4'(g_r)][SW-1];
            end
            5'd2, 5'd4, 5'd6: t_r <= prod_r;
            5'd3: d_r[0] <= t_r[DW-1:0] - prod_r[DW-1:0];
            5'd5: d_r[1] <= t_r[DW-1:0] - prod_r[DW-1:0];
            5'd7: begin
              d_r[2] <= t_r[DW-1:0] - prod_r[DW-1:0];
            end
            5'd8: r_r <= r_sel;
            5'd9: begin
              if ({{(PW-DW){1'b0}}, iaod_pkg::abs_d(d_r[r_r])} < prod_u) begin
                o_stat_r <= iaod_pkg::STAT_NO_ROLL;
                o_short_r <= short_ph;
                out_valid_r <= 1'b1;
                state_r <= ST_IDLE;
              end
              inv_r[0] <= d_r[r_r][DW-1];
              inv_r[5] <= gyr_sum_r[4'(r_r)][SW-1];
            end
            5'd10: t_r <= prod_r;
            5'd11: begin
              dpm_r <= iaod_pkg::abs_d(t_r[DW-1:0] - prod_r[DW-1:0]);
              inv_r[1] <= ((t_r[DW-1:0] - prod_r[DW-1:0]) >> (DW - 1)) != '0;
              inv_r[3] <= gyr_sum_r[4'd3 + 4'(p_ax)][SW-1];
            end
            5'd12: ;
            5'd13: warn_r[0] <= {{(PW-DW){1'b0}}, dpm_r} < prod_u;
            5'd14: y_r <= sq_beats(sq_r[y_up1], sq_r[g_r]) ? y_up1 : g_r;
            5'd15: begin
              t_r <= prod_r;
              if (sq_beats(sq_r[mod3({1'b0, y_r} + 3'd2)], sq_r[y_r])) y_r <= y_up2;
            end
            default: begin
              o_stat_r  <= iaod_pkg::STAT_OK;
              o_warn_r  <= {({{(PW-QW){1'b0}}, sq_r[y_r]} < $unsigned(t_r)), warn_r[0]};
              o_roll_r  <= r_r;
              o_pitch_r <= p_ax;
              o_grav_r  <= g_r;
              o_yaw_r   <= y_r;
              o_inv_r   <= {inv_r[5],
                            (gyr_sum_r[4'd6 + 4'(y_r)] > SW'(0)),
                            inv_r[3:0]};
              o_short_r <= short_ph;
              out_valid_r <= 1'b1;
              state_r <= ST_IDLE;
            end
          endcase
        end

        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

>>> tb/sv/imu_axis_orientation_detect_tb.sv
// testbench for imu_axis_orientation_detect: drives samples, clears and evaluates
// through the stream ports and checks every result against a local predictor
// depends on iaod_pkg and the imu_axis_orientation_detect rtl
`timescale 1ns / 100ps

class orient_scoreboard;
  // thresholds and sums, mirroring the block
  int unsigned grav_min, roll_min, pitch_min, yaw_min, tap_thr;
  longint acc_sum[9];
  longint gyr_sum[9];
  longint unsigned sq_sum[3];
  int unsigned cnt[4];
  logic [23:0] expected_q[$];
  int errors;
  int n_results, n_taps, n_ok, n_nograv, n_noroll, n_drops;

  function new();
    grav_min = 2458; roll_min = 819; pitch_min = 614; yaw_min = 80; tap_thr = 7373;
    clear_sums();
    errors = 0;
  endfunction

  function void clear_sums();
    for (int i = 0; i < 9; i++) begin
      acc_sum[i] = 0;
      gyr_sum[i] = 0;
    end
    for (int i = 0; i < 3; i++) sq_sum[i] = 0;
    for (int i = 0; i < 4; i++) cnt[i] = 0;
  endfunction

  function void write_reg(logic [2:0] idx, logic [14:0] val);
    case (idx)
      iaod_pkg::REG_GRAVITY_MIN: grav_min = val;
      iaod_pkg::REG_ROLL_MIN:    roll_min = val;
      iaod_pkg::REG_PITCH_WARN:  pitch_min = val;
      iaod_pkg::REG_YAW_RMS:     yaw_min = val;
      iaod_pkg::REG_TAP_THR:     tap_thr = val;
      default: ;
    endcase
  endfunction

  static function longint absv(longint v);
    return v < 0 ? -v : v;
  endfunction

  static function longint cnt_or_one(int unsigned n);
    return n ? longint'(n) : 1;
  endfunction

  // axis mapping on evaluate: fields status..invert_flags packed from bit 1
  function logic [23:0] map_axes();
    longint nf, nr, nt, ns, dp;
    longint d[3];
    int g, r, p, y;
    logic [5:0] inv;
    logic [1:0] warn;
    logic [23:0] res;
    nf = cnt_or_one(cnt[0]); nr = cnt_or_one(cnt[1]);
    nt = cnt_or_one(cnt[2]); ns = cnt_or_one(cnt[3]);
    res = '0; inv = '0; warn = '0; g = 0;
    for (int i = 1; i < 3; i++) if (absv(acc_sum[i]) > absv(acc_sum[g])) g = i;
    if (absv(acc_sum[g]) < longint'(grav_min) * nf) begin
      res[2:1] = iaod_pkg::STAT_NO_GRAV;
      n_nograv++;
      return res;
    end
    if (acc_sum[g] < 0) inv[2] = 1'b1;
    for (int i = 0; i < 3; i++) d[i] = acc_sum[3+i] * nf - acc_sum[i] * nr;
    d[g] = 0;
    r = (g == 0) ? 1 : 0;
    for (int i = 0; i < 3; i++) if (i != g && absv(d[i]) > absv(d[r])) r = i;
    if (absv(d[r]) < longint'(roll_min) * nr * nf) begin
      res[2:1] = iaod_pkg::STAT_NO_ROLL;
      n_noroll++;
      return res;
    end
    if (d[r] < 0) inv[0] = 1'b1;
    if (gyr_sum[r] < 0) inv[5] = 1'b1;
    p = 3 - g - r;
    dp = acc_sum[6+p] * nf - acc_sum[p] * nt;
    if (dp < 0) inv[1] = 1'b1;
    if (gyr_sum[3+p] < 0) inv[3] = 1'b1;
    if (absv(dp) < longint'(pitch_min) * nt * nf) warn[0] = 1'b1;
    y = g;
    if (4 * sq_sum[(y+1)%3] > 9 * sq_sum[y]) y = (g + 1) % 3;
    if (4 * sq_sum[(y+2)%3] > 9 * sq_sum[y]) y = (g + 2) % 3;
    if (gyr_sum[6+y] > 0) inv[4] = 1'b1;
    if (sq_sum[y] < longint'(yaw_min) * longint'(yaw_min) * longint'(ns)) warn[1] = 1'b1;
    res[2:1] = iaod_pkg::STAT_OK;
    res[4:3] = warn;
    res[6:5] = r[1:0];
    res[8:7] = p[1:0];
    res[10:9] = g[1:0];
    res[12:11] = y[1:0];
    res[18:13] = inv;
    n_ok++;
    return res;
  endfunction

  function void note_request(logic [3:0] user, logic [95:0] data);
    logic [1:0] act, ph;
    longint a[3], gy[3];
    longint unsigned m2;
    logic [23:0] res;
    act = user[1:0]; ph = user[3:2];
    res = '0;
    for (int i = 0; i < 3; i++) begin
      a[i] = longint'($signed(data[16*i +: 16]));
      gy[i] = longint'($signed(data[48 + 16*i +: 16]));
    end
    if (act == iaod_pkg::ACT_CLEAR) begin
      clear_sums();
    end else if (act == iaod_pkg::ACT_SAMPLE) begin
      m2 = a[0]*a[0] + a[1]*a[1] + a[2]*a[2];
      res[0] = m2 > longint'(tap_thr) * longint'(tap_thr);
      if (res[0]) n_taps++;
      if (cnt[ph] < iaod_pkg::MAX_SAMPLES) begin
        cnt[ph]++;
        for (int i = 0; i < 3; i++) begin
          if (ph <= 2) acc_sum[ph*3+i] += a[i];
          if (ph >= 1) gyr_sum[(ph-1)*3+i] += gy[i];
          if (ph == 3) sq_sum[i] += gy[i] * gy[i];
        end
      end else n_drops++;
    end else if (act == iaod_pkg::ACT_EVAL) begin
      res = map_axes();
      for (int i = 0; i < 4; i++) if (cnt[i] < iaod_pkg::SHORT_LIMIT) res[19+i] = 1'b1;
    end
    expected_q.push_back(res);
  endfunction

  task check_result(logic [23:0] got);
    logic [23:0] want;
    n_results++;
    if (expected_q.size() == 0) begin
      report_mismatch("result with nothing expected", '0, got);
      return;
    end
    want = expected_q.pop_front();
    if (got[0] !== want[0]) report_mismatch("tap_detected", want, got);
    if (got[2:1] !== want[2:1]) report_mismatch("status", want, got);
    if (got[4:3] !== want[4:3]) report_mismatch("warnings", want, got);
    if (got[6:5] !== want[6:5]) report_mismatch("roll_sel", want, got);
    if (got[8:7] !== want[8:7]) report_mismatch("pitch_sel", want, got);
    if (got[10:9] !== want[10:9]) report_mismatch("gravity_axis", want, got);
    if (got[12:11] !== want[12:11]) report_mismatch("yaw_sel", want, got);
    if (got[18:13] !== want[18:13]) report_mismatch("invert_flags", want, got);
    if (got[22:19] !== want[22:19]) report_mismatch("short_phases", want, got);
  endtask

  task report_mismatch(string what, logic [23:0] want, logic [23:0] got);
    errors++;
    $display("mismatch %0s: expected %06h got %06h", what, want, got);
  endtask
endclass

module imu_axis_orientation_detect_tb;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [95:0] in_tdata = '0;
  logic [3:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [23:0] out_tdata;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [14:0] cfg_data = '0;

  orient_scoreboard sb;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_off = 0;
  int n_sent = 0;
  longint cycles = 0;
  localparam longint CYCLE_LIMIT = 2000000;

  always #5 clk = ~clk;

  imu_axis_orientation_detect dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // receiver: random stalls, plus a long hold-off when asked
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("status: fail");
      $finish;
    end
  end

  // valid stays up between back-to-back requests and drops only while idling
  task automatic send_request(logic [1:0] act, logic [1:0] ph, logic [95:0] data);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= {ph, act};
    in_tdata <= data;
    do @(posedge clk); while (!in_tready);
    sb.note_request({ph, act}, data);
    n_sent++;
  endtask

  task automatic write_reg(logic [2:0] idx, logic [14:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, val);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  function automatic logic [15:0] rand_val();
    case ($urandom_range(5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'($urandom_range(400)) - 16'd200;
      default: return 16'($urandom);
    endcase
  endfunction

  // sample near a nominal vector: axis gets value, others small noise
  function automatic logic [95:0] shaped(int ax, int val, int gax, int gval);
    logic [95:0] d;
    for (int i = 0; i < 3; i++) begin
      d[16*i +: 16] = (i == ax) ? 16'(val + int'($urandom_range(200)) - 100)
                                : 16'(int'($urandom_range(400)) - 200);
      d[48+16*i +: 16] = (i == gax) ? 16'(gval + int'($urandom_range(200)) - 100)
                                    : 16'(int'($urandom_range(100)) - 50);
    end
    return d;
  endfunction

  // one gesture session: clear, four phases with random axes and occasional random samples, evaluate
  task automatic run_session(int per_phase);
    int g, r, p, y, sg, sr, sp, sy;
    g = $urandom_range(2);
    r = (g + 1 + $urandom_range(1)) % 3;
    p = 3 - g - r;
    y = $urandom_range(2);
    sg = $urandom_range(1) ? 4096 : -4096;
    sr = $urandom_range(1) ? 2000 : -2000;
    sp = $urandom_range(1) ? int'($urandom_range(2000)) : -int'($urandom_range(2000));
    sy = $urandom_range(1) ? int'($urandom_range(3000)) : -int'($urandom_range(3000));
    send_request(iaod_pkg::ACT_CLEAR, 2'($urandom), {$urandom, $urandom, $urandom});
    for (int k = 0; k < per_phase; k++) begin
      send_request(iaod_pkg::ACT_SAMPLE, 2'd0, shaped(g, sg, 0, 0));
      send_request(iaod_pkg::ACT_SAMPLE, 2'd1, shaped(r, sr, r, sr));
      send_request(iaod_pkg::ACT_SAMPLE, 2'd2, shaped(p, sp, p, sp));
      send_request(iaod_pkg::ACT_SAMPLE, 2'd3, shaped(y, sy, y, sy));
      if ($urandom_range(9) == 0)
        send_request(iaod_pkg::ACT_SAMPLE, 2'($urandom),
                     {rand_val(), rand_val(), rand_val(),
                      rand_val(), rand_val(), rand_val()});
    end
    send_request(iaod_pkg::ACT_EVAL, 2'($urandom), {$urandom, $urandom, $urandom});
  endtask

  task automatic random_phase(int n_items);
    int start;
    start = n_sent;
    while (n_sent - start < n_items) begin
      if ($urandom_range(4) != 0) begin
        run_session($urandom_range(1) ? $urandom_range(3) : $urandom_range(25));
      end else begin
        // noise: any action, any field values
        send_request(2'($urandom_range(3)), 2'($urandom),
                     {rand_val(), rand_val(), rand_val(), rand_val(), rand_val(), rand_val()});
      end
    end
  endtask

  initial begin
    sb = new();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extremes, every action, empty evaluate, tie, unused action
    send_request(iaod_pkg::ACT_EVAL, 2'd0, '0);
    send_request(iaod_pkg::ACT_SAMPLE, 2'd0, {6{16'h8000}});
    send_request(iaod_pkg::ACT_SAMPLE, 2'd1, {6{16'h7fff}});
    send_request(iaod_pkg::ACT_SAMPLE, 2'd2, '0);
    send_request(iaod_pkg::ACT_SAMPLE, 2'd3,
                 {16'h8000, 16'h7fff, 16'h8000, 16'h8000, 16'h7fff, 16'h8000});
    send_request(iaod_pkg::ACT_EVAL, 2'd3, '1);
    send_request(iaod_pkg::ACT_NONE, 2'd1, '1);
    send_request(iaod_pkg::ACT_EVAL, 2'd0, '0);
    send_request(iaod_pkg::ACT_CLEAR, 2'd0, '0);
    send_request(iaod_pkg::ACT_SAMPLE, 2'd0, {48'd0, 16'd4096, 16'd4096, 16'd4096});
    send_request(iaod_pkg::ACT_SAMPLE, 2'd1, {48'd0, 16'd4096, 16'd4096, 16'd4096});
    send_request(iaod_pkg::ACT_EVAL, 2'd0, '0);
    send_request(iaod_pkg::ACT_SAMPLE, 2'd0, {48'd0, 16'd0, 16'd7373, 16'd0});
    send_request(iaod_pkg::ACT_SAMPLE, 2'd0, {48'd0, 16'd0, 16'd7374, 16'd0});
    send_request(iaod_pkg::ACT_EVAL, 2'd2, '0);
    drain();

    // long receiver hold-off while the sender keeps offering
    hold_off = 300;
    for (int k = 0; k < 20; k++)
      send_request(iaod_pkg::ACT_SAMPLE, 2'($urandom), {$urandom, $urandom, $urandom});
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 78; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 78; end
        3: begin send_idle_pct = 8;  recv_stall_pct = 8;  end
        default: ;
      endcase
      case (ph)
        0: begin
          write_reg(iaod_pkg::REG_GRAVITY_MIN, 15'd2458);
          write_reg(iaod_pkg::REG_ROLL_MIN, 15'd819);
          write_reg(iaod_pkg::REG_PITCH_WARN, 15'd614);
          write_reg(iaod_pkg::REG_YAW_RMS, 15'd80);
          write_reg(iaod_pkg::REG_TAP_THR, 15'd7373);
        end
        1: begin
          write_reg(iaod_pkg::REG_GRAVITY_MIN, 15'd0);
          write_reg(iaod_pkg::REG_ROLL_MIN, 15'd0);
          write_reg(iaod_pkg::REG_PITCH_WARN, 15'd0);
          write_reg(iaod_pkg::REG_YAW_RMS, 15'd0);
          write_reg(iaod_pkg::REG_TAP_THR, 15'd4096);
        end
        2: begin
          write_reg(iaod_pkg::REG_GRAVITY_MIN, 15'h7fff);
          write_reg(iaod_pkg::REG_ROLL_MIN, 15'h7fff);
          write_reg(iaod_pkg::REG_PITCH_WARN, 15'h7fff);
          write_reg(iaod_pkg::REG_YAW_RMS, 15'h7fff);
          write_reg(iaod_pkg::REG_TAP_THR, 15'h7fff);
        end
        3: begin
          write_reg(iaod_pkg::REG_GRAVITY_MIN, 15'($urandom_range(4000)));
          write_reg(iaod_pkg::REG_ROLL_MIN, 15'($urandom_range(2500)));
          write_reg(iaod_pkg::REG_PITCH_WARN, 15'($urandom_range(2000)));
          write_reg(iaod_pkg::REG_YAW_RMS, 15'($urandom_range(3000)));
          write_reg(iaod_pkg::REG_TAP_THR, 15'($urandom));
        end
        default: ;
      endcase
      random_phase(160);
      // pause until everything is back before the next setting
      drain();
    end

    drain();
    $display("covered %0d results: %0d ok, %0d no-gravity, %0d no-roll evaluates",
             sb.n_results, sb.n_ok, sb.n_nograv, sb.n_noroll);
    $display("%0d taps, %0d samples dropped on full phases", sb.n_taps, sb.n_drops);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
